FILE: sv/slle_pkg.sv
`default_nettype none

package slle_pkg;

    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    // Link value that ends the list (one past the last slot)
    localparam logic [IDX_W-1:0] END_IDX  = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic       load;        // latch operation, start walk at head
        logic       alloc;       // write value into next free slot
        logic       step_cur;    // cur <= link of cur, count step
        logic       set_prev;    // prev <= cur
        logic       unlink;      // bypass cur from prev (or head)
        logic       link_new;    // link of new slot <= cur
        logic       link_prev;   // link of prev (or head) <= new slot
        logic       emit;        // drive one result next cycle
        logic       emit_data;   // result carries the value read
        logic       emit_last;   // result is the last of this operation
        logic [1:0] emit_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       head_empty;
        logic       walk_end;
        logic       rd_less;
        logic       rd_even;
        logic       rd_last;
    } t_stat;

    function automatic logic [IDX_W-1:0] norm_link(input logic [IDX_W-1:0] x);
        return (x >= END_IDX) ? END_IDX : x;
    endfunction

endpackage

`default_nettype wire

FILE: sv/sorted_linked_list_engine.sv
`default_nettype none

// Sorted linked-list engine. Holds up to CAPACITY (64) signed 32-bit values in
// ascending order as a singly linked list in on-chip value and link stores.
// Issue a command by raising start while busy is low; the transfer happens at
// that clock edge and busy rises on the next cycle. i_func selects the command:
// insert i_data_value, read out the whole list in order, or remove every even
// value. Results appear on o_out_value, o_last_item and o_status for exactly one
// cycle, marked by o_valid; the receiver cannot stall them, so capture every
// strobe. Insert, remove and an unused code each give one result with
// o_last_item set; insert reports store full when all slots have been used
// (removed slots are never reused). Read-out gives one result per stored value,
// the last one marked, or a single list-empty result. Each list step goes
// through a check state and an evaluate state, because each entry is read
// through the single registered read port of the stores. Insert stops in front
// of the first larger or equal entry, or lands at the tail. After reset the
// list is empty and no clearing pass is needed.

module sorted_linked_list_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_func,
    input  wire logic signed [slle_pkg::VAL_W-1:0] i_data_value,
    output logic                               o_valid,
    output logic signed [slle_pkg::VAL_W-1:0]  o_out_value,
    output logic                               o_last_item,
    output logic [1:0]                         o_status
);
    import slle_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [VAL_W-1:0] w_out_value;

    // Sequence each command: walk the list one entry at a time
    slle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Hold the stores, walk pointers and registered result
    slle_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_func),
        .i_data_value (i_data_value),
        .o_stat       (w_stat),
        .o_valid      (o_valid),
        .o_out_value  (w_out_value),
        .o_last_item  (o_last_item),
        .o_status     (o_status)
    );

    assign o_out_value = $signed(w_out_value);

endmodule

`default_nettype wire

FILE: sv/slle_dp.sv
`default_nettype none

module slle_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire slle_pkg::t_cmd                i_cmd,
    input  wire logic [1:0]                    i_func,
    input  wire logic [slle_pkg::VAL_W-1:0]    i_data_value,
    output slle_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    output logic [slle_pkg::VAL_W-1:0]         o_out_value,
    output logic                               o_last_item,
    output logic [1:0]                         o_status
);
    import slle_pkg::*;

    logic [VAL_W-1:0] r_vals  [CAPACITY];
    logic [IDX_W-1:0] r_links [CAPACITY];

    logic [1:0]       r_func;
    logic [VAL_W-1:0] r_value;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_free;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] r_cur, r_prev, r_steps;
    logic [VAL_W-1:0] r_rd_val;
    logic [IDX_W-1:0] r_rd_link;

    logic              w_prev_end;
    logic              w_link_we;
    logic [ADDR_W-1:0] w_link_addr;
    logic [IDX_W-1:0]  w_link_data;

    assign w_prev_end = (r_prev >= END_IDX);

    always_comb begin
        w_link_we   = 1'b0;
        w_link_addr = r_prev[ADDR_W-1:0];
        w_link_data = r_slot;
        n_head      = r_head;
        if (i_cmd.link_new) begin
            w_link_we   = 1'b1;
            w_link_addr = r_slot[ADDR_W-1:0];
            w_link_data = norm_link(r_cur);
        end else if (i_cmd.link_prev) begin
            if (w_prev_end) begin
                n_head = r_slot;
            end else begin
                w_link_we = 1'b1;
            end
        end else if (i_cmd.unlink) begin
            w_link_data = norm_link(r_rd_link);
            if (w_prev_end) begin
                n_head = norm_link(r_rd_link);
            end else begin
                w_link_we = 1'b1;
            end
        end
    end

    // Value and link stores: one write, one registered read at cur
    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_vals[r_free[ADDR_W-1:0]] <= r_value;
        end
        r_rd_val <= r_vals[r_cur[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_links[w_link_addr] <= w_link_data;
        end
        r_rd_link <= r_links[r_cur[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= END_IDX;
            r_free  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            o_valid <= i_cmd.emit;
            if (i_cmd.alloc) begin
                r_free <= r_free + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_data_value;
            r_cur   <= r_head;
            r_prev  <= END_IDX;
            r_steps <= '0;
        end else begin
            if (i_cmd.set_prev) begin
                r_prev <= r_cur;
            end
            if (i_cmd.step_cur) begin
                r_cur   <= r_rd_link;
                r_steps <= r_steps + 1'b1;
            end
        end
        if (i_cmd.alloc) begin
            r_slot <= r_free;
        end
        if (i_cmd.emit) begin
            o_out_value <= i_cmd.emit_data ? r_rd_val : '0;
            o_last_item <= i_cmd.emit_last;
            o_status    <= i_cmd.emit_status;
        end
    end

    always_comb begin
        o_stat.func       = r_func;
        o_stat.full       = (r_free >= END_IDX);
        o_stat.head_empty = (r_head >= END_IDX);
        o_stat.walk_end   = (r_cur >= END_IDX) || (r_steps >= END_IDX);
        o_stat.rd_less    = ($signed(r_rd_val) < $signed(r_value));
        o_stat.rd_even    = ~r_rd_val[0];
        o_stat.rd_last    = (r_rd_link >= END_IDX) || (r_steps == LAST_IDX);
    end

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !o_stat.full)
        else $error("slot allocated while store full");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.unlink || i_cmd.link_prev |=> r_head <= END_IDX)
        else $error("head index out of range");

    a_link_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link_we && !i_cmd.link_new |-> r_prev < END_IDX)
        else $error("link write to end marker");

endmodule

`default_nettype wire

FILE: sv/slle_ctrl.sv
`default_nettype none

module slle_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire slle_pkg::t_stat i_stat,
    output slle_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);
    import slle_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_INS_CHK  = 4'd2;
    localparam logic [3:0] S_INS_EVAL = 4'd3;
    localparam logic [3:0] S_INS_LINK = 4'd4;
    localparam logic [3:0] S_INS_HEAD = 4'd5;
    localparam logic [3:0] S_RD_CHK   = 4'd6;
    localparam logic [3:0] S_RD_EVAL  = 4'd7;
    localparam logic [3:0] S_RM_CHK   = 4'd8;
    localparam logic [3:0] S_RM_EVAL  = 4'd9;

    logic [3:0] r_state, n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FUNC_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_FULL;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.alloc = 1'b1;
                            n_state     = S_INS_CHK;
                        end
                    end
                    FUNC_READ: begin
                        if (i_stat.head_empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_last   = 1'b1;
                            o_cmd.emit_status = ST_EMPTY;
                            n_state           = S_IDLE;
                        end else begin
                            n_state = S_RD_CHK;
                        end
                    end
                    FUNC_REMOVE: begin
                        n_state = S_RM_CHK;
                    end
                    default: begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.emit_status = ST_OK;
                        n_state           = S_IDLE;
                    end
                endcase
            end
            S_INS_CHK: begin
                n_state = i_stat.walk_end ? S_INS_LINK : S_INS_EVAL;
            end
            S_INS_EVAL: begin
                if (i_stat.rd_less) begin
                    o_cmd.set_prev = 1'b1;
                    o_cmd.step_cur = 1'b1;
                    n_state        = S_INS_CHK;
                end else begin
                    n_state = S_INS_LINK;
                end
            end
            S_INS_LINK: begin
                o_cmd.link_new = 1'b1;
                n_state        = S_INS_HEAD;
            end
            S_INS_HEAD: begin
                o_cmd.link_prev   = 1'b1;
                o_cmd.emit        = 1'b1;
                o_cmd.emit_last   = 1'b1;
                o_cmd.emit_status = ST_OK;
                n_state           = S_IDLE;
            end
            S_RD_CHK: begin
                n_state = S_RD_EVAL;
            end
            S_RD_EVAL: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_data   = 1'b1;
                o_cmd.emit_last   = i_stat.rd_last;
                o_cmd.emit_status = ST_OK;
                o_cmd.step_cur    = 1'b1;
                n_state           = i_stat.rd_last ? S_IDLE : S_RD_CHK;
            end
            S_RM_CHK: begin
                if (i_stat.walk_end) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_OK;
                    n_state           = S_IDLE;
                end else begin
                    n_state = S_RM_EVAL;
                end
            end
            S_RM_EVAL: begin
                o_cmd.unlink   = i_stat.rd_even;
                o_cmd.set_prev = ~i_stat.rd_even;
                o_cmd.step_cur = 1'b1;
                n_state        = S_RM_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted command did not raise busy");

    a_one_command_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.link_new, o_cmd.link_prev, o_cmd.unlink}) <= 1)
        else $error("conflicting link store writes");

endmodule

`default_nettype wire

FILE: tb/sorted_list_checker.sv
`default_nettype none

module sorted_list_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic                              i_busy,
    input  wire logic [1:0]                        i_func,
    input  wire logic signed [slle_pkg::VAL_W-1:0] i_data_value,
    input  wire logic                              i_valid,
    input  wire logic signed [slle_pkg::VAL_W-1:0] i_out_value,
    input  wire logic                              i_last_item,
    input  wire logic [1:0]                        i_status,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import slle_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [1:0]              status;
    } t_list_result;

    // Shadow copy of the list stores
    logic signed [VAL_W-1:0] slot_value [CAPACITY];
    logic [IDX_W-1:0]        slot_link  [CAPACITY];
    logic [IDX_W-1:0]        list_head;
    logic [IDX_W-1:0]        free_slot;

    t_list_result expected_results[$];
    t_list_result want;
    int           fail_count;

    function automatic void queue_result(input logic signed [VAL_W-1:0] v,
                                         input logic l, input logic [1:0] st);
        t_list_result r;
        r.value  = v;
        r.last   = l;
        r.status = st;
        expected_results.push_back(r);
    endfunction

    task automatic insert_value(input logic signed [VAL_W-1:0] v,
                                output logic [1:0] st);
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] prev;
        int               steps;
        st = ST_OK;
        if (free_slot >= END_IDX) begin
            st = ST_FULL;
        end else begin
            slot      = free_slot;
            free_slot = free_slot + 1'b1;
            slot_value[slot[ADDR_W-1:0]] = v;
            prev  = END_IDX;
            cur   = list_head;
            steps = 0;
            // pass every entry strictly below the new value
            while (cur < END_IDX && steps < CAPACITY &&
                   slot_value[cur[ADDR_W-1:0]] < v) begin
                prev  = cur;
                cur   = slot_link[cur[ADDR_W-1:0]];
                steps++;
            end
            slot_link[slot[ADDR_W-1:0]] = cur;
            if (prev >= END_IDX) begin
                list_head = slot;
            end else begin
                slot_link[prev[ADDR_W-1:0]] = slot;
            end
        end
    endtask

    task automatic drop_even_values();
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] nxt;
        int               steps;
        cur   = list_head;
        prev  = END_IDX;
        steps = 0;
        while (cur < END_IDX && steps < CAPACITY) begin
            nxt = slot_link[cur[ADDR_W-1:0]];
            if (!slot_value[cur[ADDR_W-1:0]][0]) begin
                if (prev >= END_IDX) begin
                    list_head = nxt;
                end else begin
                    slot_link[prev[ADDR_W-1:0]] = nxt;
                end
            end else begin
                prev = cur;
            end
            cur = nxt;
            steps++;
        end
    endtask

    task automatic read_out_values();
        logic [IDX_W-1:0] cur;
        int               steps;
        t_list_result     tail;
        if (list_head >= END_IDX) begin
            queue_result('0, 1'b1, ST_EMPTY);
        end else begin
            cur   = list_head;
            steps = 0;
            while (cur < END_IDX && steps < CAPACITY) begin
                queue_result(slot_value[cur[ADDR_W-1:0]], 1'b0, ST_OK);
                cur = slot_link[cur[ADDR_W-1:0]];
                steps++;
            end
            tail = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endtask

    task automatic predict_command(input logic [1:0] f,
                                   input logic signed [VAL_W-1:0] v);
        logic [1:0] st;
        case (f)
            FUNC_INSERT: begin
                insert_value(v, st);
                queue_result('0, 1'b1, st);
            end
            FUNC_READ: begin
                read_out_values();
            end
            FUNC_REMOVE: begin
                drop_even_values();
                queue_result('0, 1'b1, ST_OK);
            end
            default: begin
                queue_result('0, 1'b1, ST_OK);
            end
        endcase
    endtask

    function automatic void report(input string what, input longint exp_v,
                                   input longint act_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, what, exp_v, act_v);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CAPACITY; k++) begin
                slot_value[k] = '0;
                slot_link[k]  = END_IDX;
            end
            list_head  = END_IDX;
            free_slot  = '0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_valid) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result mismatch, expected none, actual value %0d",
                             $time, i_out_value);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_value !== want.value) begin
                        report("out_value", want.value, i_out_value);
                        fail_count++;
                    end
                    if (i_last_item !== want.last) begin
                        report("last_item", want.last, i_last_item);
                        fail_count++;
                    end
                    if (i_status !== want.status) begin
                        report("status", want.status, i_status);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_command(i_func, i_data_value);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb_sorted_linked_list_engine.sv
`default_nettype none

module tb_sorted_linked_list_engine;

    import slle_pkg::*;

    // The block leaves this code unused; it must answer one plain ok result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 150;   // longest walk over a full list, with margin
    localparam int RANDOM_ITEMS = 70;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    start      = 1'b0;
    logic [1:0]              func       = FUNC_INSERT;
    logic signed [VAL_W-1:0] data_value = '0;
    logic                    busy;
    logic                    valid;
    logic signed [VAL_W-1:0] out_value;
    logic                    last_item;
    logic [1:0]              status;

    int fail_count;
    int pending;
    int cycles = 0;
    int burst_left = 0;
    int inserts_sent = 0;

    // 10 time unit period
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_linked_list_engine dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (func),
        .i_data_value (data_value),
        .o_valid      (valid),
        .o_out_value  (out_value),
        .o_last_item  (last_item),
        .o_status     (status)
    );

    // The checker mirrors the list, predicts every result and counts mismatches
    sorted_list_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (func),
        .i_data_value (data_value),
        .i_valid      (valid),
        .i_out_value  (out_value),
        .i_last_item  (last_item),
        .i_status     (status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mix full-range values with a narrow band around zero (duplicates, close
    // neighbors, both parities) and the signed extremes.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            return $signed($urandom);
        end else if (sel < 8) begin
            return VAL_W'(int'($urandom_range(0, 16)) - 8);
        end else begin
            case ($urandom_range(0, 5))
                0:       return 32'sh8000_0000;
                1:       return 32'sh8000_0001;
                2:       return 32'sh7fff_ffff;
                3:       return 32'sh7fff_fffe;
                4:       return '0;
                default: return -32'sd1;
            endcase
        end
    endfunction

    // Present one command and hold it until the block takes it. Call right
    // after a rising edge; return right after the edge of the transfer.
    task automatic issue(input logic [1:0] f, input logic signed [VAL_W-1:0] v);
        start      <= 1'b1;
        func       <= f;
        data_value <= v;
        if (f == FUNC_INSERT) begin
            inserts_sent++;
        end
        do @(posedge clk); while (busy);
    endtask

    // Send in bursts: between bursts drop start for a random gap and scramble
    // the idle payload. Long gaps let the block drain, short ones land on
    // every phase of a walk; long bursts give stretches with no idling.
    task automatic send(input logic [1:0] f, input logic signed [VAL_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 7))
                0:       gap = $urandom_range(40, 160);
                1, 2:    gap = 1;
                default: gap = $urandom_range(1, 20);
            endcase
            start      <= 1'b0;
            func       <= 2'($urandom);
            data_value <= $signed($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        issue(f, v);
    endtask

    // Hold off the sender until every predicted result has been seen
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int r;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: read-out reports empty, removal and the unused code are plain ok
        send(FUNC_READ,   '0);
        send(FUNC_REMOVE, 32'sh7fff_ffff);
        send(FUNC_UNUSED, 32'sh8000_0000);

        // Single even entry, removed from the head, leaving the list empty
        send(FUNC_INSERT, '0);
        send(FUNC_READ,   -32'sd1);
        send(FUNC_REMOVE, '0);
        send(FUNC_READ,   '0);

        // Extremes, a duplicate, and evens at the head, in the middle and next to the tail
        send(FUNC_INSERT, 32'sh7fff_ffff);
        send(FUNC_INSERT, 32'sh8000_0000);
        send(FUNC_INSERT, -32'sd1);
        send(FUNC_INSERT, 32'sd1);
        send(FUNC_INSERT, 32'sd1);
        send(FUNC_INSERT, -32'sd2);
        send(FUNC_INSERT, 32'sd2);
        send(FUNC_INSERT, 32'sh7fff_fffe);
        send(FUNC_INSERT, 32'sh8000_0001);
        send(FUNC_READ,   '0);
        send(FUNC_REMOVE, -32'sd1);
        send(FUNC_READ,   '0);
        send(FUNC_UNUSED, 32'sh7fff_ffff);
        send(FUNC_INSERT, 32'sd3);
        send(FUNC_READ,   '0);

        wait_drained();

        // Random mix; insert often enough that the store fills late in the run
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send(FUNC_INSERT, pick_value());
            end else if (r < 70) begin
                send(FUNC_READ, pick_value());
            end else if (r < 88) begin
                send(FUNC_REMOVE, pick_value());
            end else begin
                send(FUNC_UNUSED, pick_value());
            end
            if ($urandom_range(0, 29) == 0) begin
                wait_drained();
            end
        end

        // Use up every slot, then knock on the full store
        while (inserts_sent < CAPACITY + 2) begin
            send(FUNC_INSERT, pick_value());
        end
        send(FUNC_READ,   pick_value());
        send(FUNC_REMOVE, pick_value());
        send(FUNC_READ,   pick_value());
        send(FUNC_INSERT, pick_value());
        send(FUNC_UNUSED, pick_value());

        // Drain, then give the block time to show any stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
